@@ design/vcrp_pkg.sv @@
`timescale 1ns / 1ps

package vcrp_pkg;

  // Store sizes and the address widths that follow from them.
  localparam int unsigned SpriteBytes  = 256;
  localparam int unsigned PaletteBytes = 32;
  localparam int unsigned SprAw        = $clog2(SpriteBytes);
  localparam int unsigned PalAw        = $clog2(PaletteBytes);

  // Renderer lockout window, palette window in video memory, address steps and masks.
  localparam logic [8:0]  LastVisibleLine = 9'd240;
  localparam logic [8:0]  PreRenderLine   = 9'd261;
  localparam logic [13:0] LastChrAddress  = 14'h3EFF;
  localparam logic [14:0] IncAcross       = 15'd1;
  localparam logic [14:0] IncDown         = 15'd32;
  localparam logic [7:0]  GreyMask        = 8'h30;
  localparam logic [7:0]  AttrMask        = 8'hE3;

  // Kind of transaction on the input channel.
  typedef enum logic [1:0] {
    MODE_READ    = 2'd0,
    MODE_WRITE   = 2'd1,
    MODE_VBL_SET = 2'd2,
    MODE_VBL_CLR = 2'd3
  } mode_e;

  // CPU-visible register numbers.
  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_ADDR = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_e;

  // Palette mirroring: the backdrop entries of the sprite palettes fold onto
  // the matching background entries.
  function automatic logic [PalAw-1:0] pal_index(input logic [PalAw-1:0] a);
    logic [PalAw-1:0] i;
    i = a;
    if (i[1:0] == 2'b00 && i[4]) begin
      i[4] = 1'b0;
    end
    return i;
  endfunction

endpackage

@@ design/video_chip_register_port.sv @@
`timescale 1ns / 1ps

// CPU register port of the picture unit: control, mask, status, sprite memory
// address and data, scroll, address and data port.
// Input channel (in_valid_i / in_ready_o) carries one transaction per CPU bus
// access or vblank event; the output channel (out_valid_o / out_ready_i)
// returns exactly one result per input transaction, in order.
// The result is registered: a transaction's result enters the output
// register at the edge that accepts the transaction. Throughput is one
// transaction per cycle while the receiver takes each result, set by the
// single result register, which is refilled in the same cycle that it is
// emptied. A data port read outside the rendering lockout sets mem_read_o;
// the following transaction must carry the external byte at the
// vram_address_o just reported. A data port write below the palette window
// and outside the lockout is shown on mem_write_o with its address and byte.
// Reset clears every state register, the palette store and the sprite memory
// valid bits, so the block is ready to accept as soon as reset is released.
// When the receiver stalls, the result holds and at most one more transaction
// waits at the input until the result is taken.
module video_chip_register_port
  import vcrp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [2:0]  reg_index_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  chr_read_data_i,
  input  logic [8:0]  scanline_i,
  input  logic        sprite_overflow_i,
  input  logic        sprite_zero_hit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic        nmi_line_o,
  output logic [13:0] vram_address_o,
  output logic        mem_read_o,
  output logic        mem_write_o,
  output logic [13:0] mem_write_address_o,
  output logic [7:0]  mem_write_data_o,
  output logic [7:0]  ctrl_bits_o,
  output logic [7:0]  mask_bits_o,
  output logic [14:0] temp_address_o,
  output logic [2:0]  fine_x_o
);

  // Architectural state.
  logic [14:0]      v_q, v_d;
  logic [14:0]      t_q, t_d;
  logic [2:0]       fine_x_q, fine_x_d;
  logic             toggle_q, toggle_d;
  logic [7:0]       rbuf_q, rbuf_d;
  logic [7:0]       bus_q, bus_d;
  logic [7:0]       ctrl_q, ctrl_d;
  logic [7:0]       mask_q, mask_d;
  logic [SprAw-1:0] spr_addr_q, spr_addr_d;
  logic             vbl_q, vbl_d;

  // Stores.
  logic [7:0]             pal_q [PaletteBytes];
  logic [7:0]             spr_mem [SpriteBytes];
  logic [SpriteBytes-1:0] spr_vld_q;
  logic [7:0]             spr_rdata_q;
  logic                   spr_rvld_q;

  // Result register.
  logic        out_valid_q;
  logic [7:0]  rd_q, rd_d;
  logic        mrd_q, mrd_d;
  logic        mwr_q, mwr_d;
  logic [13:0] waddr_q, waddr_d;
  logic [7:0]  wdata_q, wdata_d;

  logic             accept;
  logic             locked;
  logic [13:0]      a14;
  logic [14:0]      inc;
  logic [PalAw-1:0] pal_idx;
  logic             pal_we;
  logic [7:0]       pal_rd;
  logic             spr_we;
  logic [7:0]       spr_wdata;
  mode_e            mode;
  reg_e             rsel;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign mode       = mode_e'(mode_i);
  assign rsel       = reg_e'(reg_index_i);

  // Shared decode of the current address and the rendering lockout.
  assign a14     = v_q[13:0];
  assign inc     = ctrl_q[2] ? IncDown : IncAcross;
  assign locked  = (mask_q[3] || mask_q[4]) &&
                   (scanline_i <= LastVisibleLine || scanline_i == PreRenderLine);
  assign pal_idx = pal_index(a14[PalAw-1:0]);
  assign pal_rd  = mask_q[0] ? (pal_q[pal_idx] & GreyMask) : pal_q[pal_idx];

  // Next state and result for one transaction.
  always_comb begin
    v_d        = v_q;
    t_d        = t_q;
    fine_x_d   = fine_x_q;
    toggle_d   = toggle_q;
    rbuf_d     = rbuf_q;
    bus_d      = bus_q;
    ctrl_d     = ctrl_q;
    mask_d     = mask_q;
    spr_addr_d = spr_addr_q;
    vbl_d      = vbl_q;
    rd_d       = 8'd0;
    mrd_d      = 1'b0;
    mwr_d      = 1'b0;
    waddr_d    = 14'd0;
    wdata_d    = 8'd0;
    pal_we     = 1'b0;
    spr_we     = 1'b0;
    spr_wdata  = write_data_i;
    if (accept) begin
      unique case (mode)
        MODE_READ: begin
          unique case (rsel)
            REG_STATUS: begin
              rd_d     = {vbl_q, sprite_zero_hit_i, sprite_overflow_i, bus_q[4:0]};
              toggle_d = 1'b0;
              vbl_d    = 1'b0;
            end
            REG_OAM_DATA: begin
              rd_d = spr_rvld_q ? spr_rdata_q : 8'd0;
            end
            REG_DATA: begin
              if (!locked) begin
                rd_d   = (a14 <= LastChrAddress) ? rbuf_q : pal_rd;
                rbuf_d = chr_read_data_i;
                mrd_d  = 1'b1;
                v_d    = v_q + inc;
              end
            end
            default: begin
              rd_d = 8'd0;
            end
          endcase
        end
        MODE_WRITE: begin
          bus_d = write_data_i;
          unique case (rsel)
            REG_CTRL: begin
              ctrl_d       = write_data_i;
              t_d[11:10]   = write_data_i[1:0];
            end
            REG_MASK: begin
              mask_d = write_data_i;
            end
            REG_OAM_ADDR: begin
              spr_addr_d = write_data_i;
            end
            REG_OAM_DATA: begin
              // Unused attribute bits read back as zero.
              if (spr_addr_q[1:0] == 2'd2) begin
                spr_wdata = write_data_i & AttrMask;
              end
              spr_we     = 1'b1;
              spr_addr_d = spr_addr_q + 1'b1;
            end
            REG_SCROLL: begin
              if (!toggle_q) begin
                fine_x_d = write_data_i[2:0];
                t_d[4:0] = write_data_i[7:3];
              end else begin
                t_d[14:12] = write_data_i[2:0];
                t_d[9:5]   = write_data_i[7:3];
              end
              toggle_d = !toggle_q;
            end
            REG_ADDR: begin
              if (!toggle_q) begin
                t_d[14]   = 1'b0;
                t_d[13:8] = write_data_i[5:0];
              end else begin
                t_d[7:0] = write_data_i;
                v_d      = {t_q[14:8], write_data_i};
              end
              toggle_d = !toggle_q;
            end
            REG_DATA: begin
              if (!locked) begin
                if (a14 <= LastChrAddress) begin
                  mwr_d   = 1'b1;
                  waddr_d = a14;
                  wdata_d = write_data_i;
                end else begin
                  pal_we = 1'b1;
                end
                v_d = v_q + inc;
              end
            end
            default: begin
              // Status writes only refresh the bus byte.
              bus_d = write_data_i;
            end
          endcase
        end
        MODE_VBL_SET: vbl_d = 1'b1;
        MODE_VBL_CLR: vbl_d = 1'b0;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q        <= '0;
      t_q        <= '0;
      fine_x_q   <= '0;
      toggle_q   <= 1'b0;
      rbuf_q     <= '0;
      bus_q      <= '0;
      ctrl_q     <= '0;
      mask_q     <= '0;
      spr_addr_q <= '0;
      vbl_q      <= 1'b0;
    end else begin
      v_q        <= v_d;
      t_q        <= t_d;
      fine_x_q   <= fine_x_d;
      toggle_q   <= toggle_d;
      rbuf_q     <= rbuf_d;
      bus_q      <= bus_d;
      ctrl_q     <= ctrl_d;
      mask_q     <= mask_d;
      spr_addr_q <= spr_addr_d;
      vbl_q      <= vbl_d;
    end
  end

  // Palette store, small enough to keep in flip-flops.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PaletteBytes; i++) begin
        pal_q[i] <= '0;
      end
    end else if (pal_we) begin
      pal_q[pal_idx] <= write_data_i;
    end
  end

  // Sprite memory. It is read ahead at the next sprite address, so the
  // registered read data always belongs to the current address; a write goes
  // to the current address, which is never the one being read ahead.
  always_ff @(posedge clk_i) begin
    if (spr_we) begin
      spr_mem[spr_addr_q] <= spr_wdata;
    end
    spr_rdata_q <= spr_mem[spr_addr_d];
  end

  // Valid bits make never-written sprite entries read as zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_vld_q  <= '0;
      spr_rvld_q <= 1'b0;
    end else begin
      if (spr_we) begin
        spr_vld_q[spr_addr_q] <= 1'b1;
      end
      spr_rvld_q <= spr_vld_q[spr_addr_d];
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q    <= rd_d;
      mrd_q   <= mrd_d;
      mwr_q   <= mwr_d;
      waddr_q <= waddr_d;
      wdata_q <= wdata_d;
    end
  end

  // The state registers already hold the post-transaction values while the
  // result is shown, since a new transaction cannot enter until it is taken.
  assign out_valid_o         = out_valid_q;
  assign read_data_o         = rd_q;
  assign nmi_line_o          = ctrl_q[7] && vbl_q;
  assign vram_address_o      = v_q[13:0];
  assign mem_read_o          = mrd_q;
  assign mem_write_o         = mwr_q;
  assign mem_write_address_o = waddr_q;
  assign mem_write_data_o    = wdata_q;
  assign ctrl_bits_o         = ctrl_q;
  assign mask_bits_o         = mask_q;
  assign temp_address_o      = t_q;
  assign fine_x_o            = fine_x_q;

endmodule

@@ design/vcrp_checker.sv @@
`timescale 1ns / 1ps

module vcrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  read_data_o,
  input logic        nmi_line_o,
  input logic        mem_read_o,
  input logic        mem_write_o,
  input logic [13:0] mem_write_address_o,
  input logic [7:0]  mem_write_data_o,
  input logic [7:0]  ctrl_bits_o
);

  // Every accepted transaction produces a result in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted transaction produced no result");

  // A stalled result keeps its read data and its read and write marks.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o)
      && $stable(mem_write_o) && $stable(mem_read_o))
    else $error("stalled result changed");

  // External write fields are zero unless a write is signalled.
  a_write_fields_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mem_write_o |-> mem_write_address_o == 14'd0
      && mem_write_data_o == 8'd0)
    else $error("write fields set without a write");

  // One transaction is either a data port read or a write, never both.
  a_read_write_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(mem_read_o && mem_write_o))
    else $error("read and write marks both set");

  // The interrupt line needs the enable bit of the control register.
  a_nmi_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && nmi_line_o |-> ctrl_bits_o[7])
    else $error("interrupt raised while disabled");

endmodule

bind video_chip_register_port vcrp_checker u_vcrp_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .read_data_o         (read_data_o),
  .nmi_line_o          (nmi_line_o),
  .mem_read_o          (mem_read_o),
  .mem_write_o         (mem_write_o),
  .mem_write_address_o (mem_write_address_o),
  .mem_write_data_o    (mem_write_data_o),
  .ctrl_bits_o         (ctrl_bits_o)
);

@@ sim/video_chip_register_port_tb.sv @@
`timescale 1ns / 1ps

module video_chip_register_port_tb;
  import vcrp_pkg::*;

  localparam int unsigned ItemTarget    = 1550;
  localparam int unsigned DrainEvery    = 500;
  localparam int unsigned LongHoldAt    = 600;
  localparam int unsigned LongHoldLen   = 80;
  localparam int unsigned WatchdogLimit = 2000;
  localparam logic [8:0]  VblLine       = 9'd250;

  // One CPU bus access or vblank event, plus a flag that makes the sender
  // wait for every outstanding result before offering it.
  typedef struct packed {
    mode_e      mode;
    reg_e       reg_idx;
    logic [7:0] wdata;
    logic [7:0] chr;
    logic [8:0] line;
    logic       ovf;
    logic       hit;
    logic       drain;
  } bus_access_t;

  typedef struct packed {
    logic [7:0]  rd;
    logic        nmi;
    logic [13:0] vaddr;
    logic        mrd;
    logic        mwr;
    logic [13:0] waddr;
    logic [7:0]  wdata;
    logic [7:0]  ctrl;
    logic [7:0]  mask;
    logic [14:0] taddr;
    logic [2:0]  fx;
  } port_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  mode = '0;
  logic [2:0]  reg_index = '0;
  logic [7:0]  write_data = '0;
  logic [7:0]  chr_read_data = '0;
  logic [8:0]  scanline = '0;
  logic        sprite_overflow = 1'b0;
  logic        sprite_zero_hit = 1'b0;
  logic        out_ready = 1'b0;

  logic        in_ready;
  logic        out_valid;
  logic [7:0]  read_data;
  logic        nmi_line;
  logic [13:0] vram_address;
  logic        mem_read;
  logic        mem_write;
  logic [13:0] mem_write_address;
  logic [7:0]  mem_write_data;
  logic [7:0]  ctrl_bits;
  logic [7:0]  mask_bits;
  logic [14:0] temp_address;
  logic [2:0]  fine_x;

  video_chip_register_port dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .mode_i              (mode),
    .reg_index_i         (reg_index),
    .write_data_i        (write_data),
    .chr_read_data_i     (chr_read_data),
    .scanline_i          (scanline),
    .sprite_overflow_i   (sprite_overflow),
    .sprite_zero_hit_i   (sprite_zero_hit),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .read_data_o         (read_data),
    .nmi_line_o          (nmi_line),
    .vram_address_o      (vram_address),
    .mem_read_o          (mem_read),
    .mem_write_o         (mem_write),
    .mem_write_address_o (mem_write_address),
    .mem_write_data_o    (mem_write_data),
    .ctrl_bits_o         (ctrl_bits),
    .mask_bits_o         (mask_bits),
    .temp_address_o      (temp_address),
    .fine_x_o            (fine_x)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bus_access_t  bus_access_q[$];
  port_result_t port_result_q[$];
  logic         drain_next = 1'b0;
  int unsigned  in_count = 0;
  int unsigned  out_count = 0;
  int unsigned  mismatches = 0;
  int unsigned  n_data_port = 0;
  int unsigned  n_palette = 0;
  int unsigned  n_locked = 0;
  int unsigned  n_ext_writes = 0;
  int unsigned  n_ext_reads = 0;

  // Shadow copy of the register port state.
  logic [14:0] sh_v;
  logic [14:0] sh_t;
  logic [2:0]  sh_fx;
  logic        sh_toggle;
  logic [7:0]  sh_rbuf;
  logic [7:0]  sh_bus;
  logic [7:0]  sh_ctrl;
  logic [7:0]  sh_mask;
  logic [7:0]  sh_oam_ptr;
  logic        sh_vbl;
  logic [7:0]  sprite_shadow [SpriteBytes];
  logic [7:0]  palette_shadow [PaletteBytes];

  task automatic clear_shadow();
    sh_v = '0;
    sh_t = '0;
    sh_fx = '0;
    sh_toggle = 1'b0;
    sh_rbuf = '0;
    sh_bus = '0;
    sh_ctrl = '0;
    sh_mask = '0;
    sh_oam_ptr = '0;
    sh_vbl = 1'b0;
    for (int i = 0; i < SpriteBytes; i++) sprite_shadow[i] = '0;
    for (int i = 0; i < PaletteBytes; i++) palette_shadow[i] = '0;
  endtask

  // Applies one transaction to the shadow state and works out its result.
  task automatic apply_bus_access(input bus_access_t a, output port_result_t r);
    logic [14:0] step;
    logic [13:0] a14;
    logic [4:0]  pidx;
    logic        locked;
    logic [7:0]  d;
    r = '0;
    step = sh_ctrl[2] ? IncDown : IncAcross;
    a14 = sh_v[13:0];
    // Sprite palette backdrops fold onto the background backdrops.
    pidx = a14[4:0];
    if (pidx[1:0] == 2'b00) pidx[4] = 1'b0;
    locked = (sh_mask[4:3] != 2'b00) &&
             (a.line <= LastVisibleLine || a.line == PreRenderLine);
    d = a.wdata;
    if (a.reg_idx == REG_DATA && (a.mode == MODE_READ || a.mode == MODE_WRITE)) begin
      n_data_port++;
      if (locked) n_locked++;
      else if (a14 > LastChrAddress) n_palette++;
    end
    case (a.mode)
      MODE_READ: begin
        case (a.reg_idx)
          REG_STATUS: begin
            r.rd = {sh_vbl, a.hit, a.ovf, sh_bus[4:0]};
            sh_toggle = 1'b0;
            sh_vbl = 1'b0;
          end
          REG_OAM_DATA: r.rd = sprite_shadow[sh_oam_ptr];
          REG_DATA: begin
            if (!locked) begin
              if (a14 <= LastChrAddress) begin
                r.rd = sh_rbuf;
              end else begin
                r.rd = palette_shadow[pidx];
                if (sh_mask[0]) r.rd = r.rd & GreyMask;
              end
              sh_rbuf = a.chr;
              r.mrd = 1'b1;
              sh_v = sh_v + step;
            end
          end
          default: ;
        endcase
      end
      MODE_WRITE: begin
        sh_bus = d;
        case (a.reg_idx)
          REG_CTRL: begin
            sh_ctrl = d;
            sh_t[11:10] = d[1:0];
          end
          REG_MASK: sh_mask = d;
          REG_OAM_ADDR: sh_oam_ptr = d;
          REG_OAM_DATA: begin
            // Attribute bytes have three unimplemented bits.
            if (sh_oam_ptr[1:0] == 2'b10) d = d & AttrMask;
            sprite_shadow[sh_oam_ptr] = d;
            sh_oam_ptr = sh_oam_ptr + 8'd1;
          end
          REG_SCROLL: begin
            if (!sh_toggle) begin
              sh_fx = d[2:0];
              sh_t[4:0] = d[7:3];
            end else begin
              sh_t[14:12] = d[2:0];
              sh_t[9:5] = d[7:3];
            end
            sh_toggle = ~sh_toggle;
          end
          REG_ADDR: begin
            if (!sh_toggle) begin
              sh_t[13:8] = d[5:0];
              sh_t[14] = 1'b0;
            end else begin
              sh_t[7:0] = d;
              sh_v = sh_t;
            end
            sh_toggle = ~sh_toggle;
          end
          REG_DATA: begin
            if (!locked) begin
              if (a14 <= LastChrAddress) begin
                r.mwr = 1'b1;
                r.waddr = a14;
                r.wdata = d;
              end else begin
                palette_shadow[pidx] = d;
              end
              sh_v = sh_v + step;
            end
          end
          default: ;
        endcase
      end
      MODE_VBL_SET: sh_vbl = 1'b1;
      MODE_VBL_CLR: sh_vbl = 1'b0;
    endcase
    r.nmi = sh_ctrl[7] & sh_vbl;
    r.vaddr = sh_v[13:0];
    r.ctrl = sh_ctrl;
    r.mask = sh_mask;
    r.taddr = sh_t;
    r.fx = sh_fx;
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  // Stimulus helpers.
  function automatic logic [8:0] pick_line();
    case ($urandom_range(0, 9))
      0, 1: return 9'($urandom_range(0, 261));
      2: return 9'($urandom_range(0, 511));
      default: return 9'($urandom_range(241, 260));
    endcase
  endfunction

  task automatic queue_access(input mode_e m, input reg_e r, input logic [7:0] d,
                              input logic [8:0] line);
    bus_access_t a;
    a.mode = m;
    a.reg_idx = r;
    a.wdata = d;
    a.chr = 8'($urandom);
    a.line = line;
    a.ovf = 1'($urandom);
    a.hit = 1'($urandom);
    a.drain = drain_next;
    drain_next = 1'b0;
    bus_access_q.push_back(a);
  endtask

  task automatic queue_random_sequences();
    logic [7:0]  hi;
    logic [7:0]  base;
    int unsigned run;
    int unsigned next_drain;
    next_drain = bus_access_q.size() + DrainEvery;
    while (bus_access_q.size() < ItemTarget) begin
      if (bus_access_q.size() >= next_drain) begin
        drain_next = 1'b1;
        next_drain += DrainEvery;
      end
      case ($urandom_range(0, 19))
        // Point v somewhere, often the palette window, then use the data port.
        0, 1, 2, 3, 4, 5: begin
          if ($urandom_range(0, 3) != 0)
            queue_access(MODE_READ, REG_STATUS, 8'($urandom), pick_line());
          hi = 8'($urandom);
          if ($urandom_range(0, 2) == 0) hi[5:0] = 6'h3F;
          queue_access(MODE_WRITE, REG_ADDR, hi, pick_line());
          queue_access(MODE_WRITE, REG_ADDR, 8'($urandom), pick_line());
          run = $urandom_range(1, 10);
          repeat (run)
            queue_access($urandom_range(0, 1) ? MODE_READ : MODE_WRITE, REG_DATA,
                         8'($urandom), pick_line());
        end
        // Sprite memory fill and read back.
        6, 7, 8: begin
          base = 8'($urandom);
          queue_access(MODE_WRITE, REG_OAM_ADDR, base, pick_line());
          run = $urandom_range(1, 8);
          repeat (run) queue_access(MODE_WRITE, REG_OAM_DATA, 8'($urandom), pick_line());
          queue_access(MODE_WRITE, REG_OAM_ADDR, base + 8'($urandom_range(0, run)),
                       pick_line());
          queue_access(MODE_READ, REG_OAM_DATA, 8'($urandom), pick_line());
        end
        // Scroll pair.
        9, 10: begin
          if ($urandom_range(0, 1))
            queue_access(MODE_READ, REG_STATUS, 8'($urandom), pick_line());
          queue_access(MODE_WRITE, REG_SCROLL, 8'($urandom), pick_line());
          queue_access(MODE_WRITE, REG_SCROLL, 8'($urandom), pick_line());
        end
        // Control and mask, rendering often switched off.
        11, 12: begin
          queue_access(MODE_WRITE, REG_CTRL, 8'($urandom), pick_line());
          hi = 8'($urandom);
          if ($urandom_range(0, 1)) hi[4:3] = 2'b00;
          queue_access(MODE_WRITE, REG_MASK, hi, pick_line());
        end
        // Vblank events around status reads.
        13, 14: begin
          queue_access(MODE_VBL_SET, reg_e'($urandom_range(0, 7)), 8'($urandom),
                       pick_line());
          if ($urandom_range(0, 1))
            queue_access(MODE_READ, REG_STATUS, 8'($urandom), pick_line());
          else
            queue_access(MODE_VBL_CLR, reg_e'($urandom_range(0, 7)), 8'($urandom),
                         pick_line());
        end
        15, 16: begin
          queue_access($urandom_range(0, 1) ? MODE_READ : MODE_WRITE, REG_STATUS,
                       8'($urandom), pick_line());
        end
        // Noise: anything the fields allow.
        default: begin
          run = $urandom_range(1, 3);
          repeat (run)
            queue_access(mode_e'($urandom_range(0, 3)), reg_e'($urandom_range(0, 7)),
                         8'($urandom), 9'($urandom_range(0, 511)));
        end
      endcase
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  bus_access_t drv_item;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_ready) begin
        // Transaction still waiting; hold it.
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (bus_access_q.size() != 0 &&
                   (!bus_access_q[0].drain || (!in_valid && in_count == out_count))) begin
        drv_item = bus_access_q.pop_front();
        in_valid <= 1'b1;
        mode <= drv_item.mode;
        reg_index <= drv_item.reg_idx;
        write_data <= drv_item.wdata;
        chr_read_data <= drv_item.chr;
        scanline <= drv_item.line;
        sprite_overflow <= drv_item.ovf;
        sprite_zero_hit <= drv_item.hit;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: a rotating, regularly redrawn ready pattern, plus one long
  // hold-off that lets the block fill up and stall its input.
  int unsigned hold_left = 0;
  int unsigned phase_cnt = 0;
  logic        long_hold_done = 1'b0;
  logic [15:0] ready_pattern = '1;

  always @(posedge clk) begin
    if (rst_n) begin
      if (!long_hold_done && out_count >= LongHoldAt) begin
        long_hold_done = 1'b1;
        hold_left = LongHoldLen;
      end
      if (phase_cnt % 256 == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pattern = '1;
          1: ready_pattern = 16'($urandom);
          2: ready_pattern = 16'($urandom | $urandom);
          default: ready_pattern = 16'($urandom & $urandom) | 16'd1;
        endcase
      end
      phase_cnt++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ready_pattern[phase_cnt % 16];
      end
    end
  end

  // Monitor: checks each result against the oldest prediction, then predicts
  // the result of any transaction accepted at this edge.
  bus_access_t  mon_item;
  port_result_t mon_want;
  port_result_t mon_new;

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_shadow();
    end else begin
      if (out_valid && out_ready) begin
        out_count <= out_count + 1;
        if (port_result_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: result arrived with nothing expected", $time);
        end else begin
          mon_want = port_result_q.pop_front();
          check_field("read_data", mon_want.rd, read_data);
          check_field("nmi_line", mon_want.nmi, nmi_line);
          check_field("vram_address", mon_want.vaddr, vram_address);
          check_field("mem_read", mon_want.mrd, mem_read);
          check_field("mem_write", mon_want.mwr, mem_write);
          check_field("mem_write_address", mon_want.waddr, mem_write_address);
          check_field("mem_write_data", mon_want.wdata, mem_write_data);
          check_field("ctrl_bits", mon_want.ctrl, ctrl_bits);
          check_field("mask_bits", mon_want.mask, mask_bits);
          check_field("temp_address", mon_want.taddr, temp_address);
          check_field("fine_x", mon_want.fx, fine_x);
        end
      end
      if (in_valid && in_ready) begin
        in_count <= in_count + 1;
        mon_item = '0;
        mon_item.mode = mode_e'(mode);
        mon_item.reg_idx = reg_e'(reg_index);
        mon_item.wdata = write_data;
        mon_item.chr = chr_read_data;
        mon_item.line = scanline;
        mon_item.ovf = sprite_overflow;
        mon_item.hit = sprite_zero_hit;
        apply_bus_access(mon_item, mon_new);
        n_ext_reads += mon_new.mrd;
        n_ext_writes += mon_new.mwr;
        port_result_q.push_back(mon_new);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
      $display("video_chip_register_port verification failed");
      $finish;
    end
  end

  // Directed opening, random sequences, reset and the end of the run.
  initial begin
    // Vblank flag, nmi line, status write and status read.
    queue_access(MODE_VBL_SET, REG_CTRL, 8'h00, VblLine);
    queue_access(MODE_WRITE, REG_CTRL, 8'h80, VblLine);
    queue_access(MODE_WRITE, REG_STATUS, 8'hFF, VblLine);
    queue_access(MODE_READ, REG_STATUS, 8'h00, VblLine);
    queue_access(MODE_VBL_CLR, REG_STATUS, 8'h00, VblLine);
    // Write-only registers read back as zero.
    queue_access(MODE_READ, REG_CTRL, 8'h00, VblLine);
    queue_access(MODE_READ, REG_MASK, 8'h00, VblLine);
    queue_access(MODE_READ, REG_OAM_ADDR, 8'h00, VblLine);
    queue_access(MODE_READ, REG_SCROLL, 8'h00, VblLine);
    queue_access(MODE_READ, REG_ADDR, 8'h00, VblLine);
    // Attribute byte clearing and sprite address wrap; reads do not step.
    queue_access(MODE_WRITE, REG_OAM_ADDR, 8'hFE, VblLine);
    queue_access(MODE_WRITE, REG_OAM_DATA, 8'hFF, VblLine);
    queue_access(MODE_WRITE, REG_OAM_DATA, 8'hFF, VblLine);
    queue_access(MODE_READ, REG_OAM_DATA, 8'h00, VblLine);
    // Build v = 0x7FFF through scroll and address writes, then wrap it.
    queue_access(MODE_WRITE, REG_ADDR, 8'hFF, VblLine);
    queue_access(MODE_WRITE, REG_SCROLL, 8'hFF, VblLine);
    queue_access(MODE_WRITE, REG_SCROLL, 8'hFF, VblLine);
    queue_access(MODE_WRITE, REG_ADDR, 8'hFF, VblLine);
    queue_access(MODE_WRITE, REG_DATA, 8'hFF, VblLine);
    // Palette mirror write, then greyscale read and rendering lockout.
    queue_access(MODE_WRITE, REG_ADDR, 8'h3F, VblLine);
    queue_access(MODE_WRITE, REG_ADDR, 8'h10, VblLine);
    queue_access(MODE_WRITE, REG_DATA, 8'hFF, VblLine);
    queue_access(MODE_WRITE, REG_MASK, 8'h19, VblLine);
    queue_access(MODE_WRITE, REG_ADDR, 8'h3F, VblLine);
    queue_access(MODE_WRITE, REG_ADDR, 8'h00, VblLine);
    queue_access(MODE_READ, REG_DATA, 8'h00, 9'd100);
    queue_access(MODE_READ, REG_DATA, 8'h00, VblLine);
    queue_access(MODE_WRITE, REG_CTRL, 8'h04, VblLine);
    queue_access(MODE_WRITE, REG_DATA, 8'hA5, PreRenderLine);
    drain_next = 1'b1;
    queue_random_sequences();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Sampled between rising edges, once every update of the edge has settled.
    while (bus_access_q.size() != 0 || in_valid || in_count != out_count) @(negedge clk);
    repeat (4) @(posedge clk);
    if (port_result_q.size() != 0) begin
      mismatches += port_result_q.size();
      $display("%0t ns: %0d results never arrived", $time, port_result_q.size());
    end

    $display("Covered %0d transactions: %0d data port accesses, %0d in the palette window,",
             in_count, n_data_port, n_palette);
    $display("%0d locked out by rendering, %0d external reads and %0d external writes.",
             n_locked, n_ext_reads, n_ext_writes);
    if (mismatches == 0) begin
      $display("video_chip_register_port verification clean");
    end else begin
      $display("video_chip_register_port verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/vcrp_pkg.sv
design/video_chip_register_port.sv
design/vcrp_checker.sv
sim/video_chip_register_port_tb.sv
